// ===== hw/rtl/csc_pkg.sv =====
// ----------------------------------------------------------------------------
// csc_pkg
// Shared types, sizes and register indexes of the cross stencil counter.
// ----------------------------------------------------------------------------
package csc_pkg;

  // frame geometry and pixel format
  localparam int MAX_COLS   = 1024;
  localparam int MAX_ROWS   = 1024;
  localparam int PIXEL_BITS = 8;

  localparam int COL_W   = $clog2(MAX_COLS);
  localparam int ROW_W   = $clog2(MAX_ROWS);
  localparam int ENTRY_W = 2 * PIXEL_BITS;

  // cross sum of five pixels
  localparam int SUM_W = $clog2(5 * ((1 << PIXEL_BITS) - 1) + 1);

  // configuration registers
  localparam int CFG_W   = 11;
  localparam int CFG_A_W = 2;

  localparam logic [CFG_A_W-1:0] REG_FRAME_ROWS = CFG_A_W'(0);
  localparam logic [CFG_A_W-1:0] REG_FRAME_COLS = CFG_A_W'(1);
  localparam logic [CFG_A_W-1:0] REG_THRESHOLD  = CFG_A_W'(2);

  localparam logic [CFG_W-1:0] FRAME_ROWS_RESET = CFG_W'(1024);
  localparam logic [CFG_W-1:0] FRAME_COLS_RESET = CFG_W'(1024);
  localparam logic [CFG_W-1:0] THRESHOLD_RESET  = CFG_W'(30);

  // hit counter
  localparam int                 COUNT_W   = 20;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // one classified pixel, handed from front to back
  typedef struct packed {
    logic             sof;
    logic             interior;
    logic             last;
    logic [SUM_W-1:0] sum;
  } csc_item_t;

endpackage

// ===== hw/rtl/csc_front.sv =====
// ----------------------------------------------------------------------------
// csc_front
// Raster position tracking, line store and cross window. Each accepted pixel
// leaves as one classified item carrying its cross sum.
// ----------------------------------------------------------------------------
module csc_front
  import csc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  output logic                  ready_o,
  input  logic [PIXEL_BITS-1:0] pixel_value_i,
  input  logic                  start_of_frame_i,
  input  logic [CFG_W-1:0]      frame_rows_i,
  input  logic [CFG_W-1:0]      frame_cols_i,
  input  logic [QCNT_W-1:0]     q_free_i,
  output logic                  q_push_o,
  output csc_item_t             q_item_o
);

  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic [COL_W-1:0] cols_m1;
  logic [ROW_W-1:0] rows_m1;
  logic [COL_W-1:0] col_cur;
  logic [ROW_W-1:0] row_cur;
  logic             accept;
  logic             row_end;
  logic             frame_end;

  // second stage registers
  logic                  s1_valid_q;
  logic [COL_W-1:0]      s1_addr_q;
  logic [PIXEL_BITS-1:0] s1_pix_q;
  logic                  s1_sof_q;
  logic                  s1_interior_q;
  logic                  s1_last_q;
  logic                  byp_q;
  logic [ENTRY_W-1:0]    byp_data_q;
  logic [ENTRY_W-1:0]    rdata_q;

  // cross window
  logic [PIXEL_BITS-1:0] win_up_q;
  logic [PIXEL_BITS-1:0] win_mid_q;
  logic [PIXEL_BITS-1:0] win_mid2_q;
  logic [PIXEL_BITS-1:0] win_down_q;

  logic [ENTRY_W-1:0]    entry;
  logic [PIXEL_BITS-1:0] mid_c;
  logic [PIXEL_BITS-1:0] up_c;
  logic [ENTRY_W-1:0]    wdata;
  logic [SUM_W-1:0]      sum;

  // line store: low half one row up, high half two rows up
  logic [ENTRY_W-1:0] line_mem [MAX_COLS];

  // clamp the frame size to the supported range, kept as size minus one
  always_comb begin
    if (frame_cols_i == '0) begin
      cols_m1 = '0;
    end else if (32'(frame_cols_i) > MAX_COLS) begin
      cols_m1 = COL_W'(MAX_COLS - 1);
    end else begin
      cols_m1 = COL_W'(frame_cols_i - 1'b1);
    end
    if (frame_rows_i == '0) begin
      rows_m1 = '0;
    end else if (32'(frame_rows_i) > MAX_ROWS) begin
      rows_m1 = ROW_W'(MAX_ROWS - 1);
    end else begin
      rows_m1 = ROW_W'(frame_rows_i - 1'b1);
    end
  end

  // room for the new request and the one still in the second stage
  assign ready_o = (q_free_i > QCNT_W'(s1_valid_q));
  assign accept  = push_i && ready_o;

  // position of this pixel and the next one
  always_comb begin
    col_cur   = start_of_frame_i ? '0 : col_q;
    row_cur   = start_of_frame_i ? '0 : row_q;
    row_end   = (col_cur >= cols_m1);
    frame_end = row_end && (row_cur >= rows_m1);
    col_d     = col_q;
    row_d     = row_q;
    if (accept) begin
      if (row_end) begin
        col_d = '0;
        row_d = frame_end ? '0 : row_cur + 1'b1;
      end else begin
        col_d = col_cur + 1'b1;
        row_d = row_cur;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      col_q      <= col_d;
      row_q      <= row_d;
      s1_valid_q <= accept;
    end
  end

  // first stage: read the column entry, note a same-cycle write to it
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rdata_q       <= line_mem[col_cur];
      byp_q         <= s1_valid_q && (s1_addr_q == col_cur);
      byp_data_q    <= wdata;
      s1_addr_q     <= col_cur;
      s1_pix_q      <= pixel_value_i;
      s1_sof_q      <= start_of_frame_i;
      s1_interior_q <= (row_cur >= ROW_W'(2)) && (col_cur >= COL_W'(2));
      s1_last_q     <= frame_end;
    end
  end

  // second stage: cross sum and line store update
  always_comb begin
    entry = byp_q ? byp_data_q : rdata_q;
    mid_c = entry[PIXEL_BITS-1:0];
    up_c  = entry[ENTRY_W-1:PIXEL_BITS];
    wdata = {mid_c, s1_pix_q};
    sum   = SUM_W'(win_up_q) + SUM_W'(win_mid2_q) + SUM_W'(win_mid_q)
          + SUM_W'(mid_c) + SUM_W'(win_down_q);
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      line_mem[s1_addr_q] <= wdata;
    end
  end

  // window shift
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_up_q   <= '0;
      win_mid_q  <= '0;
      win_mid2_q <= '0;
      win_down_q <= '0;
    end else if (s1_valid_q) begin
      win_mid2_q <= win_mid_q;
      win_mid_q  <= mid_c;
      win_up_q   <= up_c;
      win_down_q <= s1_pix_q;
    end
  end

  assign q_push_o          = s1_valid_q;
  assign q_item_o.sof      = s1_sof_q;
  assign q_item_o.interior = s1_interior_q;
  assign q_item_o.last     = s1_last_q;
  assign q_item_o.sum      = sum;

endmodule

// ===== hw/rtl/csc_queue.sv =====
// ----------------------------------------------------------------------------
// csc_queue
// Short queue of classified pixels between the front and the back.
// ----------------------------------------------------------------------------
module csc_queue
  import csc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  csc_item_t         item_i,
  output logic [QCNT_W-1:0] free_o,
  output logic              valid_o,
  output csc_item_t         item_o,
  input  logic              pop_i
);

  csc_item_t         slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q;
  logic [QPTR_W-1:0] rd_ptr_q;
  logic [QCNT_W-1:0] count_q;
  logic              do_pop;

  assign valid_o = (count_q != '0);
  assign item_o  = slot_q[rd_ptr_q];
  assign free_o  = QCNT_W'(QUEUE_DEPTH) - count_q;
  assign do_pop  = pop_i && valid_o;

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      count_q <= count_q + QCNT_W'(push_i) - QCNT_W'(do_pop);
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

// ===== hw/rtl/csc_back.sv =====
// ----------------------------------------------------------------------------
// csc_back
// Threshold compare, saturating hit counter and the result register.
// ----------------------------------------------------------------------------
module csc_back
  import csc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  csc_item_t          item_i,
  output logic               pop_o,
  input  logic [CFG_W-1:0]   threshold_i,
  output logic               res_valid_o,
  output logic [COUNT_W-1:0] res_count_o,
  input  logic               res_pop_i
);

  logic [COUNT_W-1:0] hit_q, hit_d;
  logic [COUNT_W-1:0] base;
  logic [COUNT_W-1:0] hit_new;
  logic               res_valid_q, res_valid_d;
  logic [COUNT_W-1:0] res_q;
  logic               room;
  logic               produce;

  // a frame end waits only for the result register to be free
  assign room    = !res_valid_q || res_pop_i;
  assign pop_o   = valid_i && (!item_i.last || room);
  assign produce = pop_o && item_i.last;

  // count update
  always_comb begin
    base    = item_i.sof ? '0 : hit_q;
    hit_new = base;
    if (item_i.interior && (base != COUNT_MAX) &&
        ({{CFG_W{1'b0}}, item_i.sum} > {{SUM_W{1'b0}}, threshold_i})) begin
      hit_new = base + 1'b1;
    end
    hit_d = hit_q;
    if (pop_o) begin
      hit_d = item_i.last ? '0 : hit_new;
    end
    res_valid_d = res_valid_q;
    if (res_pop_i) begin
      res_valid_d = 1'b0;
    end
    if (produce) begin
      res_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      hit_q       <= hit_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (produce) begin
      res_q <= hit_new;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_count_o = res_q;

endmodule

// ===== hw/rtl/cross_stencil_threshold_count.sv =====
// ----------------------------------------------------------------------------
// cross_stencil_threshold_count
// Counts interior pixels whose five-point cross sum exceeds a threshold and
// reports the count once per frame.
//
//   channel   handshake          payload
//   pixels    push / full        pixel_value_i, start_of_frame_i
//   count     empty / pop        star_count_o
//   config    cfg_we_i           cfg_index_i, cfg_wdata_i
//
// One pixel per cycle sustained; the line store has one read and one write
// port, and a same-address read and write in one cycle is forwarded.
// A frame's count passes the second stage, the queue and the result register.
// full rises only when the front-to-back queue is filling because pop is held
// low at a frame end; the line store needs no clearing pass after reset.
// ----------------------------------------------------------------------------
module cross_stencil_threshold_count
  import csc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push,
  output logic                  full,
  input  logic [PIXEL_BITS-1:0] pixel_value_i,
  input  logic                  start_of_frame_i,
  output logic                  empty,
  input  logic                  pop,
  output logic [COUNT_W-1:0]    star_count_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_A_W-1:0]    cfg_index_i,
  input  logic [CFG_W-1:0]      cfg_wdata_i
);

  logic [CFG_W-1:0]  frame_rows_q;
  logic [CFG_W-1:0]  frame_cols_q;
  logic [CFG_W-1:0]  threshold_q;
  logic              front_ready;
  logic [QCNT_W-1:0] q_free;
  logic              q_push;
  csc_item_t         q_item_in;
  logic              q_valid;
  csc_item_t         q_item_out;
  logic              q_pop;
  logic              res_valid;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_rows_q <= FRAME_ROWS_RESET;
      frame_cols_q <= FRAME_COLS_RESET;
      threshold_q  <= THRESHOLD_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_FRAME_ROWS: frame_rows_q <= cfg_wdata_i;
        REG_FRAME_COLS: frame_cols_q <= cfg_wdata_i;
        REG_THRESHOLD:  threshold_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // position, line store and cross sum
  csc_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push_i           (push),
    .ready_o          (front_ready),
    .pixel_value_i    (pixel_value_i),
    .start_of_frame_i (start_of_frame_i),
    .frame_rows_i     (frame_rows_q),
    .frame_cols_i     (frame_cols_q),
    .q_free_i         (q_free),
    .q_push_o         (q_push),
    .q_item_o         (q_item_in)
  );

  // decoupling queue
  csc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (q_item_in),
    .free_o  (q_free),
    .valid_o (q_valid),
    .item_o  (q_item_out),
    .pop_i   (q_pop)
  );

  // counting and result
  csc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (q_valid),
    .item_i      (q_item_out),
    .pop_o       (q_pop),
    .threshold_i (threshold_q),
    .res_valid_o (res_valid),
    .res_count_o (star_count_o),
    .res_pop_i   (pop)
  );

  assign full  = !front_ready;
  assign empty = !res_valid;

endmodule

// ===== dv/csc_count_checker.sv =====
// ----------------------------------------------------------------------------
// csc_count_checker
// Watches the pixel, count and register ports of the cross stencil counter,
// predicts each frame's star count from the accepted pixels and compares it
// with the count the block hands out.
// ----------------------------------------------------------------------------
module csc_count_checker import csc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push,
  input  logic                  full,
  input  logic [PIXEL_BITS-1:0] pixel_value_i,
  input  logic                  start_of_frame_i,
  input  logic                  empty,
  input  logic                  pop,
  input  logic [COUNT_W-1:0]    star_count_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_A_W-1:0]    cfg_index_i,
  input  logic [CFG_W-1:0]      cfg_wdata_i,
  output int unsigned           pending_o,
  output int unsigned           fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // shadow copy of the registers
  logic [CFG_W-1:0] rows_q;
  logic [CFG_W-1:0] cols_q;
  logic [CFG_W-1:0] thresh_q;

  // stencil state: two rows per column plus the sliding window
  logic [ENTRY_W-1:0]    line_store [MAX_COLS];
  int unsigned           col_cnt;
  int unsigned           row_cnt;
  logic [COUNT_W-1:0]    hits;
  logic [PIXEL_BITS-1:0] w_up;
  logic [PIXEL_BITS-1:0] w_mid;
  logic [PIXEL_BITS-1:0] w_mid2;
  logic [PIXEL_BITS-1:0] w_down;

  logic [COUNT_W-1:0] expected_counts [$];
  logic [COUNT_W-1:0] want;
  int unsigned        fails;

  // sizes of 0 act as 1, sizes above the store act as the store size
  function automatic int unsigned effective_size(input logic [CFG_W-1:0] v,
                                                 input int unsigned limit);
    if (v == '0) return 1;
    if (32'(v) > limit) return limit;
    return 32'(v);
  endfunction

  // one pixel through the cross window; queues the count at frame end
  task automatic advance_stencil(input logic [PIXEL_BITS-1:0] pix,
                                 input logic sof);
    int unsigned           n_rows;
    int unsigned           n_cols;
    int unsigned           c;
    int unsigned           sum;
    logic [PIXEL_BITS-1:0] mid_c;
    logic [PIXEL_BITS-1:0] up_c;
    n_rows = effective_size(rows_q, MAX_ROWS);
    n_cols = effective_size(cols_q, MAX_COLS);
    if (sof) begin
      row_cnt = 0;
      col_cnt = 0;
      hits    = '0;
    end
    c     = (col_cnt >= MAX_COLS) ? MAX_COLS - 1 : col_cnt;
    mid_c = line_store[c[COL_W-1:0]][PIXEL_BITS-1:0];
    up_c  = line_store[c[COL_W-1:0]][ENTRY_W-1:PIXEL_BITS];

    // cross centered one row up, one column left
    if (row_cnt >= 2 && c >= 2) begin
      sum = 32'(w_up) + 32'(w_mid2) + 32'(w_mid) + 32'(mid_c) + 32'(w_down);
      if (sum > 32'(thresh_q) && hits != COUNT_MAX) hits++;
    end

    w_mid2                   = w_mid;
    w_mid                    = mid_c;
    w_up                     = up_c;
    w_down                   = pix;
    line_store[c[COL_W-1:0]] = {mid_c, pix};

    // raster position, frame end emits the count
    if (col_cnt >= n_cols - 1) begin
      col_cnt = 0;
      if (row_cnt >= n_rows - 1) begin
        expected_counts.push_back(hits);
        row_cnt = 0;
        hits    = '0;
      end else begin
        row_cnt++;
      end
    end else begin
      col_cnt++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q     = FRAME_ROWS_RESET;
      cols_q     = FRAME_COLS_RESET;
      thresh_q   = THRESHOLD_RESET;
      line_store = '{default: '0};
      col_cnt    = 0;
      row_cnt    = 0;
      hits       = '0;
      w_up       = '0;
      w_mid      = '0;
      w_mid2     = '0;
      w_down     = '0;
      fails      = 0;
      expected_counts.delete();
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      // count channel
      if (pop && !empty) begin
        if (expected_counts.size() == 0) begin
          $display("%0t: star_count %0d arrived with no frame pending", $time,
                   star_count_i);
          fails++;
        end else begin
          want = expected_counts.pop_front();
          if (star_count_i !== want) begin
            $display("%0t: star_count expected %0d actual %0d", $time, want,
                     star_count_i);
            fails++;
          end
        end
      end

      // register writes
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_FRAME_ROWS: rows_q   = cfg_wdata_i;
          REG_FRAME_COLS: cols_q   = cfg_wdata_i;
          REG_THRESHOLD:  thresh_q = cfg_wdata_i;
          default: ;
        endcase
      end

      // pixel channel
      if (push && !full) advance_stencil(pixel_value_i, start_of_frame_i);

      pending_o    <= expected_counts.size();
      fail_count_o <= fails;
    end
  end

endmodule

// ===== dv/tb_cross_stencil_threshold_count.sv =====
// ----------------------------------------------------------------------------
// tb_cross_stencil_threshold_count
// Streams frames of pixels into the cross stencil counter under several frame
// sizes and thresholds, with random gaps on the pixel side and random stalls
// on the count side; the checker predicts and compares every frame count.
// ----------------------------------------------------------------------------
module tb_cross_stencil_threshold_count import csc_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned END_CYCLES     = 20;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned RANDOM_ITEMS   = 1700;
  localparam int unsigned PHASE_ITEMS    = 150;
  localparam int unsigned HOLD_PHASE     = 3;

  typedef enum int {PIX_UNIFORM, PIX_DARK, PIX_EXTREME, PIX_NEAR_THRESHOLD}
    pixel_style_e;
  typedef enum int {FRAME_FULL, FRAME_NO_SOF, FRAME_CUT} frame_kind_e;

  logic                  clk_i            = 1'b0;
  logic                  rst_ni           = 1'b0;
  logic                  push             = 1'b0;
  logic                  full;
  logic [PIXEL_BITS-1:0] pixel_value_i    = '0;
  logic                  start_of_frame_i = 1'b0;
  logic                  empty;
  logic                  pop              = 1'b0;
  logic [COUNT_W-1:0]    star_count_o;
  logic                  cfg_we_i         = 1'b0;
  logic [CFG_A_W-1:0]    cfg_index_i      = '0;
  logic [CFG_W-1:0]      cfg_wdata_i      = '0;

  int unsigned pending;
  int unsigned fail_count;
  int unsigned quiet_cycles = 0;

  // stimulus state
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_req       = 1'b0;
  bit          hold_done      = 1'b0;
  int unsigned sent_items     = 0;
  int unsigned gen_rows       = 1;
  int unsigned gen_cols       = 1;
  int unsigned cur_thr        = 30;
  bit          aligned        = 1'b0;

  cross_stencil_threshold_count dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .pixel_value_i    (pixel_value_i),
    .start_of_frame_i (start_of_frame_i),
    .empty            (empty),
    .pop              (pop),
    .star_count_o     (star_count_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i)
  );

  csc_count_checker checker_i (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .pixel_value_i    (pixel_value_i),
    .start_of_frame_i (start_of_frame_i),
    .empty            (empty),
    .pop              (pop),
    .star_count_i     (star_count_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .pending_o        (pending),
    .fail_count_o     (fail_count)
  );

  // 10 ns clock
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // count side: random stalls, or one long hold-off on request
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_req && !hold_done) begin
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_done = 1'b1;
      end else begin
        pop <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // watchdog on cycles without any accepted request
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty) || cfg_we_i) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("cross_stencil_threshold_count: mismatch");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // one pixel request, held until taken
  task automatic push_pixel(input logic [PIXEL_BITS-1:0] pix, input logic sof);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push             <= 1'b1;
    pixel_value_i    <= pix;
    start_of_frame_i <= sof;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    sent_items++;
  endtask

  // stop sending, wait for every count, then let the pipeline empty
  task automatic drain(input int unsigned pause);
    @(negedge clk_i);
    push <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (pause) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_A_W-1:0] idx,
                           input logic [CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic apply_setting(input logic [CFG_W-1:0] rows,
                               input logic [CFG_W-1:0] cols,
                               input logic [CFG_W-1:0] thr);
    drain(SETTLE_CYCLES);
    write_reg(REG_FRAME_ROWS, rows);
    write_reg(REG_FRAME_COLS, cols);
    write_reg(REG_THRESHOLD, thr);
    gen_rows = 32'(rows);
    gen_cols = 32'(cols);
    cur_thr  = 32'(thr);
  endtask

  function automatic logic [PIXEL_BITS-1:0] pick_pixel(input pixel_style_e style);
    int v;
    case (style)
      PIX_UNIFORM: v = $urandom_range(255);
      PIX_DARK:    v = $urandom_range(63);
      PIX_EXTREME: v = $urandom_range(1) ? 255 : 0;
      default: begin
        // around a fifth of the threshold so sums land near it
        v = int'(cur_thr / 5) + int'($urandom_range(6)) - 3;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
      end
    endcase
    return v[PIXEL_BITS-1:0];
  endfunction

  // a frame at the current size; a cut frame stops early, maybe restarted
  task automatic send_frame(input frame_kind_e kind, input pixel_style_e style);
    int unsigned total;
    int unsigned stop_at;
    logic        sof;
    total   = gen_rows * gen_cols;
    stop_at = total;
    if (kind == FRAME_CUT && total > 1) stop_at = $urandom_range(total - 1, 1);
    for (int unsigned k = 0; k < stop_at; k++) begin
      if (k == 0) sof = (kind != FRAME_NO_SOF) || !aligned;
      else        sof = (kind == FRAME_CUT) && ($urandom_range(15) == 0);
      push_pixel(pick_pixel(style), sof);
    end
    aligned = (stop_at == total);
  endtask

  initial begin
    int unsigned  base;
    int unsigned  phase;
    int unsigned  phase_start;
    int unsigned  rows;
    int unsigned  cols;
    int unsigned  thr;
    frame_kind_e  kind;
    pixel_style_e style;

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // zero sizes act as single-pixel frames, each gives a count of zero
    apply_setting(0, 0, 30);
    push_pixel(8'h00, 1'b1);
    push_pixel(8'hFF, 1'b0);
    push_pixel(8'h5A, 1'b1);

    // brightest cross just above the highest threshold it can exceed
    apply_setting(3, 3, 1274);
    for (int i = 0; i < 9; i++) push_pixel(8'hFF, i == 0);

    // largest sizes, then both shrunk mid-frame so row and frame end early
    apply_setting(1024, 2047, 0);
    for (int i = 0; i < 6; i++) push_pixel(pick_pixel(PIX_UNIFORM), i == 0);
    apply_setting(3, 3, 0);
    for (int i = 0; i < 7; i++) push_pixel(pick_pixel(PIX_UNIFORM), 1'b0);
    aligned = 1'b1;

    // random phases over the idle patterns
    base  = sent_items;
    phase = 0;
    while (sent_items - base < RANDOM_ITEMS) begin
      if (phase == HOLD_PHASE) begin
        // hold the count side off while small frames keep coming
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        apply_setting(3, 3, CFG_W'($urandom_range(1275)));
        hold_req = 1'b1;
        repeat (12) send_frame(FRAME_FULL, PIX_UNIFORM);
      end else begin
        case (phase % 4)
          0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
          1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
          2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
          default: begin send_idle_pct = 20; recv_stall_pct = 20; end
        endcase
        if ($urandom_range(5) == 0) begin
          rows = $urandom_range(4, 1);
          cols = $urandom_range(40, 11);
        end else begin
          rows = $urandom_range(8, 1);
          cols = $urandom_range(10, 1);
        end
        case ($urandom_range(7))
          0:       thr = 0;
          1:       thr = 1275;
          2, 3:    thr = $urandom_range(1275);
          default: thr = $urandom_range(700, 100);
        endcase
        apply_setting(CFG_W'(rows), CFG_W'(cols), CFG_W'(thr));
        phase_start = sent_items;
        while (sent_items - phase_start < PHASE_ITEMS) begin
          case ($urandom_range(9))
            0:       kind = FRAME_CUT;
            1:       kind = FRAME_NO_SOF;
            default: kind = FRAME_FULL;
          endcase
          style = pixel_style_e'($urandom_range(3));
          send_frame(kind, style);
        end
      end
      phase++;
    end

    // final drain and verdict
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    drain(END_CYCLES);
    if (fail_count == 0) begin
      $display("cross_stencil_threshold_count: match");
    end else begin
      $display("cross_stencil_threshold_count: mismatch");
    end
    $finish;
  end

endmodule
